// ===== rtl/tcw_pkg.sv =====
// ----------------------------------------------------------------------------
// tcw_pkg
// shared types and codes for the text console cell writer
// ----------------------------------------------------------------------------
package tcw_pkg;

  // request codes carried in req_type
  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_READ  = 1'b1;

  // character code that moves to the next row instead of storing
  localparam logic [7:0] NEWLINE_CODE = 8'd10;

  // reset value of the default attribute register
  localparam logic [7:0] DEFAULT_ATTR_RESET = 8'd15;

  // one screen cell, attribute in the high byte
  typedef struct packed {
    logic [7:0] attr;
    logic [7:0] code;
  } cell_t;

  localparam cell_t BLANK_CELL = '{attr: 8'd0, code: 8'd0};

endpackage

// ===== rtl/tcw_if.sv =====
// ----------------------------------------------------------------------------
// tcw_if
// valid/ready channels for command items and result items
// ----------------------------------------------------------------------------
interface tcw_cmd_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic       use_cursor;
  logic [6:0] column;
  logic [4:0] line;
  logic [7:0] char_code;
  logic [7:0] attribute;

  modport source (
    output valid, req_type, use_cursor, column, line, char_code, attribute,
    input  ready
  );
  modport sink (
    input  valid, req_type, use_cursor, column, line, char_code, attribute,
    output ready
  );
endinterface

interface tcw_res_if;
  logic       valid;
  logic       ready;
  logic [7:0] cell_char;
  logic [7:0] cell_attribute;
  logic [6:0] cursor_column;
  logic [4:0] cursor_line;
  logic       scrolled;

  modport source (
    output valid, cell_char, cell_attribute, cursor_column, cursor_line, scrolled,
    input  ready
  );
  modport sink (
    input  valid, cell_char, cell_attribute, cursor_column, cursor_line, scrolled,
    output ready
  );
endinterface

// ===== rtl/text_console_cell_writer.sv =====
// ----------------------------------------------------------------------------
// text_console_cell_writer
// text-mode screen store of COLS x ROWS cells with a linear cursor
// ----------------------------------------------------------------------------
// The screen lives in one cell memory (character byte low, attribute byte
// high). After reset the block first sweeps the memory to blank cells, one
// cell per cycle, so it takes no command item until the sweep is done; the
// default attribute register can be written at any time. After that, one
// item is handled at a time: the item is accepted in ST_IDLE (the memory
// write or read is issued in that same cycle) and its result is loaded into
// the output register from ST_RESP once that register is free. A write that
// runs past the last cell scrolls the screen: each of the COLS*(ROWS-1)
// moved cells takes a read (ST_SC_RD) and then a write (ST_SC_WR) on the
// single memory port pair, then the bottom row is blanked one cell per
// cycle. A new item is taken while the previous result still waits in the
// output register.
// ----------------------------------------------------------------------------
module text_console_cell_writer
  import tcw_pkg::*;
#(
  parameter int COLS = 80,
  parameter int ROWS = 25
) (
  input  logic          clk,
  input  logic          rst,
  tcw_cmd_if.sink       cmd,
  tcw_res_if.source     res,
  input  logic          cfg_we,
  input  logic [7:0]    cfg_data
);

  localparam int CELLS = COLS * ROWS;
  localparam int COL_W = $clog2(COLS);
  localparam int ROW_W = $clog2(ROWS);
  localparam int IDX_W = $clog2(CELLS);

  // sequencer states
  localparam logic [2:0] ST_CLEAR = 3'd0;  // blanking sweep after reset
  localparam logic [2:0] ST_IDLE  = 3'd1;  // waiting for an item
  localparam logic [2:0] ST_RESP  = 3'd2;  // hand result to the output register
  localparam logic [2:0] ST_SC_RD = 3'd3;  // scroll: read cell one row down
  localparam logic [2:0] ST_SC_WR = 3'd4;  // scroll: write it one row up
  localparam logic [2:0] ST_BLANK = 3'd5;  // scroll: blank the bottom row

  logic [2:0]       state;
  logic [IDX_W-1:0] idx;
  logic [7:0]       default_attr;

  // cursor held as column and row, no division needed for the result
  logic [COL_W-1:0] cur_col;
  logic [ROW_W-1:0] cur_row;

  // what the result of the item in flight needs
  logic pend_read;
  logic pend_scrolled;

  // output register
  logic       out_valid;
  logic [7:0] out_char;
  logic [7:0] out_attr;
  logic [6:0] out_col;
  logic [4:0] out_line;
  logic       out_scrolled;

  // memory port
  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  cell_t            mem_wdata;
  logic             mem_re;
  logic [IDX_W-1:0] mem_raddr;
  cell_t            mem_rdata;

  // target decode
  logic             accept;
  logic             target_ok;
  logic [COL_W-1:0] col_sel;
  logic [ROW_W-1:0] row_sel;
  logic [IDX_W-1:0] addr_sel;
  logic [7:0]       attr_eff;
  logic             is_newline;
  logic             do_write;
  logic             do_read;
  logic             row_end;
  logic             last_row;
  logic             out_free;

  assign cmd.ready = (state == ST_IDLE);
  assign accept    = cmd.valid && cmd.ready;
  assign out_free  = !out_valid || res.ready;

  always_comb begin
    // an explicit target off the screen leaves the memory and the cursor alone
    target_ok = cmd.use_cursor ||
                ((32'(cmd.column) < COLS) && (32'(cmd.line) < ROWS));
    col_sel   = cmd.use_cursor ? cur_col : COL_W'(cmd.column);
    row_sel   = cmd.use_cursor ? cur_row : ROW_W'(cmd.line);
    addr_sel  = IDX_W'(32'(row_sel) * COLS) + IDX_W'(col_sel);
    attr_eff  = (cmd.attribute == 8'd0) ? default_attr : cmd.attribute;
    is_newline = (cmd.char_code == NEWLINE_CODE);
    do_write  = accept && target_ok && (cmd.req_type == REQ_WRITE);
    do_read   = accept && target_ok && (cmd.req_type == REQ_READ);
    // newline always ends the row, like writing the last column
    row_end   = is_newline || (32'(col_sel) == COLS - 1);
    last_row  = (32'(row_sel) == ROWS - 1);
  end

  // memory port selection
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = idx;
    mem_wdata = BLANK_CELL;
    mem_re    = 1'b0;
    mem_raddr = addr_sel;
    case (state)
      ST_CLEAR, ST_BLANK: begin
        mem_we = 1'b1;
      end
      ST_IDLE: begin
        if (do_write && !is_newline) begin
          mem_we    = 1'b1;
          mem_waddr = addr_sel;
          mem_wdata = '{attr: attr_eff, code: cmd.char_code};
        end
        mem_re = do_read;
      end
      ST_SC_RD: begin
        mem_re    = 1'b1;
        mem_raddr = IDX_W'(32'(idx) + COLS);
      end
      ST_SC_WR: begin
        mem_we    = 1'b1;
        mem_wdata = mem_rdata;
      end
      default: begin
      end
    endcase
  end

  tcw_cell_ram #(
    .DEPTH  (CELLS),
    .ADDR_W (IDX_W)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      default_attr <= DEFAULT_ATTR_RESET;
    end else if (cfg_we) begin
      default_attr <= cfg_data;
    end
  end

  // sequencer, cursor and pending result
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_CLEAR;
      idx           <= '0;
      cur_col       <= '0;
      cur_row       <= '0;
      pend_read     <= 1'b0;
      pend_scrolled <= 1'b0;
    end else begin
      case (state)
        ST_CLEAR: begin
          if (32'(idx) == CELLS - 1) begin
            idx   <= '0;
            state <= ST_IDLE;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            pend_read     <= do_read;
            pend_scrolled <= 1'b0;
            state         <= ST_RESP;
            if (do_write) begin
              if (!row_end) begin
                cur_col <= col_sel + 1'b1;
                cur_row <= row_sel;
              end else if (!last_row) begin
                cur_col <= '0;
                cur_row <= row_sel + 1'b1;
              end else begin
                // past the last cell: land at the start of the bottom row
                cur_col       <= '0;
                cur_row       <= row_sel;
                pend_scrolled <= 1'b1;
                idx           <= '0;
                state         <= ST_SC_RD;
              end
            end
          end
        end
        ST_SC_RD: begin
          state <= ST_SC_WR;
        end
        ST_SC_WR: begin
          idx <= idx + 1'b1;
          if (32'(idx) == CELLS - COLS - 1) begin
            state <= ST_BLANK;
          end else begin
            state <= ST_SC_RD;
          end
        end
        ST_BLANK: begin
          if (32'(idx) == CELLS - 1) begin
            idx   <= '0;
            state <= ST_RESP;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        ST_RESP: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // output register, read data carries the cell only for item reads, zero otherwise
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_RESP && out_free) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_RESP && out_free) begin
      out_char     <= pend_read ? mem_rdata.code : 8'd0;
      out_attr     <= pend_read ? mem_rdata.attr : 8'd0;
      out_col      <= 7'(cur_col);
      out_line     <= 5'(cur_row);
      out_scrolled <= pend_scrolled;
    end
  end

  assign res.valid          = out_valid;
  assign res.cell_char      = out_char;
  assign res.cell_attribute = out_attr;
  assign res.cursor_column  = out_col;
  assign res.cursor_line    = out_line;
  assign res.scrolled       = out_scrolled;

endmodule

// ===== rtl/tcw_cell_ram.sv =====
// ----------------------------------------------------------------------------
// tcw_cell_ram
// screen cell memory, one write and one registered read port
// ----------------------------------------------------------------------------
module tcw_cell_ram
  import tcw_pkg::*;
#(
  parameter int DEPTH = 2000,
  parameter int ADDR_W = 11
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  cell_t             wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output cell_t             rdata
);

  cell_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
